// ----- hdl/ond_pkg.sv -----
// ---------------------------------------------------------------------------
// Octahedral normal decoder package
// Widths, pipeline geometry, stage state types and the per-step arithmetic
// of the long divider and the integer square root.
// ---------------------------------------------------------------------------
`default_nettype none

package ond_pkg;

    // Input code and per-axis magnitudes.
    localparam int CODE_W = 10;
    localparam logic [CODE_W-1:0] CODE_FULL = '1;
    localparam int MAG_W = CODE_W;
    localparam int NUM_AX = 3;
    localparam int AX_X = 0;
    localparam int AX_Y = 1;
    localparam int AX_Z = 2;

    // Squares and squared length (at most three times 1023 squared).
    localparam int CSQ_W = 2 * MAG_W;
    localparam int SQ_W = CSQ_W + 2;

    // Divider: partial remainder stays below twice the squared length.
    localparam int REM_W = SQ_W + 1;
    localparam int QUO_W = 32;
    localparam int DIV_STEPS = QUO_W;

    // Square root of the halved quotient.
    localparam int RAD_W = QUO_W;
    localparam int ROOT_W = RAD_W / 2;
    localparam int SREM_W = ROOT_W + 4;
    localparam int SQRT_STEPS = RAD_W / 2;

    // Result format.
    localparam int OUT_W = 16;

    // Pipeline geometry.
    localparam int STEPS = 2;
    localparam int DIV_STAGES = DIV_STEPS / STEPS;
    localparam int SQRT_STAGES = SQRT_STEPS / STEPS;
    localparam int PIPE_STAGES = DIV_STAGES + SQRT_STAGES;
    localparam int FRONT_STAGES = 3;
    localparam int NUM_STAGES = FRONT_STAGES + PIPE_STAGES + 1;

    typedef struct packed {
        logic [REM_W-1:0] rem;
        logic [QUO_W-1:0] quo;
    } t_div_st;

    typedef struct packed {
        logic [RAD_W-1:0]  rad;
        logic [SREM_W-1:0] rem;
        logic [ROOT_W-1:0] root;
    } t_sqrt_st;

    // One restoring division step: compare, subtract, shift.
    function automatic t_div_st div_step(input t_div_st st, input logic [SQ_W-1:0] sq);
        t_div_st nx;
        logic [REM_W-1:0] diff;
        logic take;
        take = st.rem >= {1'b0, sq};
        diff = st.rem - {1'b0, sq};
        nx.quo = {st.quo[QUO_W-2:0], take};
        nx.rem = take ? {diff[REM_W-2:0], 1'b0} : {st.rem[REM_W-2:0], 1'b0};
        return nx;
    endfunction

    // One restoring square root step, two radicand bits at a time.
    function automatic t_sqrt_st sqrt_step(input t_sqrt_st st);
        t_sqrt_st nx;
        logic [SREM_W-1:0] acc;
        logic [SREM_W-1:0] trial;
        logic take;
        acc = {st.rem[SREM_W-3:0], st.rad[RAD_W-1 -: 2]};
        trial = {{(SREM_W - ROOT_W - 2){1'b0}}, st.root, 2'b01};
        take = acc >= trial;
        nx.rad = {st.rad[RAD_W-3:0], 2'b00};
        nx.rem = take ? (acc - trial) : acc;
        nx.root = {st.root[ROOT_W-2:0], take};
        return nx;
    endfunction

endpackage

`default_nettype wire

// ----- hdl/ond_ifs.sv -----
// ---------------------------------------------------------------------------
// Octahedral normal decoder channels
// Valid/ready channels for the packed code pair and the decoded normal.
// ---------------------------------------------------------------------------
`default_nettype none

interface ond_code_if;
    logic valid;
    logic ready;
    logic [ond_pkg::CODE_W-1:0] code_x;
    logic [ond_pkg::CODE_W-1:0] code_y;

    modport source (output valid, output code_x, output code_y, input ready);
    modport sink (input valid, input code_x, input code_y, output ready);
endinterface

interface ond_normal_if;
    logic valid;
    logic ready;
    logic signed [ond_pkg::OUT_W-1:0] normal_x;
    logic signed [ond_pkg::OUT_W-1:0] normal_y;
    logic signed [ond_pkg::OUT_W-1:0] normal_z;

    modport source (output valid, output normal_x, output normal_y, output normal_z,
                    input ready);
    modport sink (input valid, input normal_x, input normal_y, input normal_z,
                  output ready);
endinterface

`default_nettype wire

// ----- hdl/ond_scale_pipe.sv -----
// ---------------------------------------------------------------------------
// Octahedral normal decoder scaling pipeline
// For each axis computes floor(sqrt(floor(2^30 * c^2 / S))) with a pipelined
// restoring divider followed by a pipelined integer square root.
// ---------------------------------------------------------------------------
`default_nettype none

module ond_scale_pipe (
    input  logic                                              i_clk,
    input  logic                                              i_en,
    input  logic [ond_pkg::SQ_W-1:0]                          i_sq,
    input  logic [ond_pkg::NUM_AX-1:0][ond_pkg::CSQ_W-1:0]    i_csq,
    input  logic [ond_pkg::NUM_AX-1:0]                        i_neg,
    output logic [ond_pkg::NUM_AX-1:0][ond_pkg::ROOT_W-1:0]   o_root,
    output logic [ond_pkg::NUM_AX-1:0]                        o_neg
);

    ond_pkg::t_div_st  r_div     [ond_pkg::DIV_STAGES][ond_pkg::NUM_AX];
    ond_pkg::t_div_st  w_div_in  [ond_pkg::DIV_STAGES][ond_pkg::NUM_AX];
    logic [ond_pkg::SQ_W-1:0] w_sq_in [ond_pkg::DIV_STAGES];
    logic [ond_pkg::SQ_W-1:0] r_sq    [ond_pkg::DIV_STAGES-1];

    ond_pkg::t_sqrt_st r_sqrt    [ond_pkg::SQRT_STAGES][ond_pkg::NUM_AX];
    ond_pkg::t_sqrt_st w_sqrt_in [ond_pkg::SQRT_STAGES][ond_pkg::NUM_AX];

    logic [ond_pkg::NUM_AX-1:0] r_neg [ond_pkg::PIPE_STAGES];

    // Divider stages. The squared length rides along with the remainders.
    for (genvar g = 0; g < ond_pkg::DIV_STAGES; g++) begin : g_div
        ond_pkg::t_div_st n_div [ond_pkg::NUM_AX];

        if (g == 0) begin : g_first
            assign w_sq_in[g] = i_sq;
            for (genvar a = 0; a < ond_pkg::NUM_AX; a++) begin : g_ax
                assign w_div_in[g][a].rem = ond_pkg::REM_W'(i_csq[a]);
                assign w_div_in[g][a].quo = '0;
            end
        end else begin : g_next
            assign w_sq_in[g] = r_sq[g-1];
            for (genvar a = 0; a < ond_pkg::NUM_AX; a++) begin : g_ax
                assign w_div_in[g][a] = r_div[g-1][a];
            end
        end

        always_comb begin
            for (int a = 0; a < ond_pkg::NUM_AX; a++) begin
                n_div[a] = w_div_in[g][a];
                for (int s = 0; s < ond_pkg::STEPS; s++) begin
                    n_div[a] = ond_pkg::div_step(n_div[a], w_sq_in[g]);
                end
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                for (int a = 0; a < ond_pkg::NUM_AX; a++) begin
                    r_div[g][a] <= n_div[a];
                end
            end
        end

        if (g < ond_pkg::DIV_STAGES - 1) begin : g_sq
            always_ff @(posedge i_clk) begin
                if (i_en) begin
                    r_sq[g] <= w_sq_in[g];
                end
            end
        end
    end

    // Square root stages. The radicand is the quotient halved, which turns
    // the divider's 2^31 scale into the 2^30 scale of the square root.
    for (genvar g = 0; g < ond_pkg::SQRT_STAGES; g++) begin : g_sqrt
        ond_pkg::t_sqrt_st n_sqrt [ond_pkg::NUM_AX];

        for (genvar a = 0; a < ond_pkg::NUM_AX; a++) begin : g_ax
            if (g == 0) begin : g_first
                assign w_sqrt_in[g][a].rad =
                    {1'b0, r_div[ond_pkg::DIV_STAGES-1][a].quo[ond_pkg::QUO_W-1:1]};
                assign w_sqrt_in[g][a].rem = '0;
                assign w_sqrt_in[g][a].root = '0;
            end else begin : g_next
                assign w_sqrt_in[g][a] = r_sqrt[g-1][a];
            end
        end

        always_comb begin
            for (int a = 0; a < ond_pkg::NUM_AX; a++) begin
                n_sqrt[a] = w_sqrt_in[g][a];
                for (int s = 0; s < ond_pkg::STEPS; s++) begin
                    n_sqrt[a] = ond_pkg::sqrt_step(n_sqrt[a]);
                end
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                for (int a = 0; a < ond_pkg::NUM_AX; a++) begin
                    r_sqrt[g][a] <= n_sqrt[a];
                end
            end
        end
    end

    // Component signs travel alongside the arithmetic.
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_neg[0] <= i_neg;
            for (int i = 1; i < ond_pkg::PIPE_STAGES; i++) begin
                r_neg[i] <= r_neg[i-1];
            end
        end
    end

    always_comb begin
        for (int a = 0; a < ond_pkg::NUM_AX; a++) begin
            o_root[a] = r_sqrt[ond_pkg::SQRT_STAGES-1][a].root;
        end
    end

    assign o_neg = r_neg[ond_pkg::PIPE_STAGES-1];

endmodule

`default_nettype wire

// ----- hdl/octahedral_normal_decoder.sv -----
// ---------------------------------------------------------------------------
// Octahedral normal decoder
// Turns a pair of 10-bit octahedral codes into a unit normal in signed Q1.14,
// rounded to nearest with ties away from zero, using exact integer math.
// ---------------------------------------------------------------------------
//
//   Channel   Port       Dir   Payload
//   --------  ---------  ----  ------------------------------------------
//   codes     i_code     in    code_x[9:0], code_y[9:0]  (unsigned)
//   normal    o_normal   out   normal_x, normal_y, normal_z  (s16, Q1.14)
//
// One transaction is taken per clock cycle, back to back, while the skid
// register is empty. A result reaches the output register behind 3 front
// stages, 16 divider and 8 square root stages (two steps each) and one
// rounding stage. i_rst_n is synchronous and active low; it drops every item
// in flight. When o_normal stalls, a skid register catches the item leaving
// the pipeline, and the whole pipeline then holds until the skid drains.
// ---------------------------------------------------------------------------
`default_nettype none

module octahedral_normal_decoder (
    input  logic         i_clk,
    input  logic         i_rst_n,
    ond_code_if.sink     i_code,
    ond_normal_if.source o_normal
);

    // Pipeline enable: the pipeline moves whenever the skid register is free.
    logic w_en;
    logic w_up_fire;

    logic [ond_pkg::NUM_STAGES-1:0] r_vld;

    // Front stage one: unfold the codes into magnitudes and signs.
    logic [ond_pkg::NUM_AX-1:0][ond_pkg::MAG_W-1:0] n_s1_mag;
    logic [ond_pkg::NUM_AX-1:0]                     n_s1_neg;
    logic [ond_pkg::NUM_AX-1:0][ond_pkg::MAG_W-1:0] r_s1_mag;
    logic [ond_pkg::NUM_AX-1:0]                     r_s1_neg;
    logic [ond_pkg::MAG_W-1:0]                      w_ax;
    logic [ond_pkg::MAG_W-1:0]                      w_ay;
    logic [ond_pkg::MAG_W:0]                        w_sum;
    logic [ond_pkg::MAG_W:0]                        w_over;
    logic [ond_pkg::MAG_W:0]                        w_under;
    logic                                           w_fold;

    // Front stage two: squares.
    logic [ond_pkg::NUM_AX-1:0][ond_pkg::CSQ_W-1:0] r_s2_csq;
    logic [ond_pkg::NUM_AX-1:0]                     r_s2_neg;

    // Front stage three: squared length.
    logic [ond_pkg::NUM_AX-1:0][ond_pkg::CSQ_W-1:0] r_s3_csq;
    logic [ond_pkg::NUM_AX-1:0]                     r_s3_neg;
    logic [ond_pkg::SQ_W-1:0]                       r_s3_sq;

    // Scaling pipeline results.
    logic [ond_pkg::NUM_AX-1:0][ond_pkg::ROOT_W-1:0] w_root;
    logic [ond_pkg::NUM_AX-1:0]                      w_neg;

    // Rounding stage, output register and skid register.
    logic [ond_pkg::NUM_AX-1:0][ond_pkg::OUT_W-1:0] n_fin;
    logic [ond_pkg::NUM_AX-1:0][ond_pkg::OUT_W-1:0] r_fin;
    logic [ond_pkg::NUM_AX-1:0][ond_pkg::OUT_W-1:0] r_out;
    logic [ond_pkg::NUM_AX-1:0][ond_pkg::OUT_W-1:0] r_skid;
    logic                                           r_out_v;
    logic                                           r_skid_v;

    assign w_en = !r_skid_v;
    assign w_up_fire = r_vld[ond_pkg::NUM_STAGES-1] && w_en;
    assign i_code.ready = w_en;

    // Valid bits travel with the data through every stage.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (w_en) begin
            r_vld <= {r_vld[ond_pkg::NUM_STAGES-2:0], i_code.valid};
        end
    end

    // A code e stands for 2e - 1023. Its magnitude is odd: the low nine bits
    // of e, inverted for the negative half, with a one appended. When the
    // magnitudes of x and y add up past 1023 the lower hemisphere is folded,
    // which leaves |x| = 1023 - |y|, |y| = 1023 - |x| and |z| = sum - 1023.
    always_comb begin
        w_ax = {i_code.code_x[ond_pkg::CODE_W-1] ? i_code.code_x[ond_pkg::CODE_W-2:0]
                                                 : ~i_code.code_x[ond_pkg::CODE_W-2:0], 1'b1};
        w_ay = {i_code.code_y[ond_pkg::CODE_W-1] ? i_code.code_y[ond_pkg::CODE_W-2:0]
                                                 : ~i_code.code_y[ond_pkg::CODE_W-2:0], 1'b1};
        w_sum = {1'b0, w_ax} + {1'b0, w_ay};
        w_fold = w_sum[ond_pkg::MAG_W];
        w_over = w_sum - {1'b0, ond_pkg::CODE_FULL};
        w_under = {1'b0, ond_pkg::CODE_FULL} - w_sum;

        n_s1_mag[ond_pkg::AX_X] = w_fold ? (ond_pkg::CODE_FULL - w_ay) : w_ax;
        n_s1_mag[ond_pkg::AX_Y] = w_fold ? (ond_pkg::CODE_FULL - w_ax) : w_ay;
        n_s1_mag[ond_pkg::AX_Z] = w_fold ? w_over[ond_pkg::MAG_W-1:0]
                                         : w_under[ond_pkg::MAG_W-1:0];

        // Folding moves x and y toward zero but never past it, so the signs
        // are those of the codes; z is negative exactly when folded.
        n_s1_neg[ond_pkg::AX_X] = !i_code.code_x[ond_pkg::CODE_W-1];
        n_s1_neg[ond_pkg::AX_Y] = !i_code.code_y[ond_pkg::CODE_W-1];
        n_s1_neg[ond_pkg::AX_Z] = w_fold;
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_s1_mag <= n_s1_mag;
            r_s1_neg <= n_s1_neg;

            for (int a = 0; a < ond_pkg::NUM_AX; a++) begin
                r_s2_csq[a] <= ond_pkg::CSQ_W'(r_s1_mag[a]) * ond_pkg::CSQ_W'(r_s1_mag[a]);
            end
            r_s2_neg <= r_s1_neg;

            r_s3_csq <= r_s2_csq;
            r_s3_neg <= r_s2_neg;
            r_s3_sq  <= ond_pkg::SQ_W'(r_s2_csq[ond_pkg::AX_X])
                      + ond_pkg::SQ_W'(r_s2_csq[ond_pkg::AX_Y])
                      + ond_pkg::SQ_W'(r_s2_csq[ond_pkg::AX_Z]);
        end
    end

    // The root k is floor(32768 * |c| / |v|); the rounded result is the
    // largest n with 2n - 1 <= k, which is (k + 1) / 2.
    ond_scale_pipe u_scale (
        .i_clk  (i_clk),
        .i_en   (w_en),
        .i_sq   (r_s3_sq),
        .i_csq  (r_s3_csq),
        .i_neg  (r_s3_neg),
        .o_root (w_root),
        .o_neg  (w_neg)
    );

    always_comb begin
        for (int a = 0; a < ond_pkg::NUM_AX; a++) begin
            n_fin[a] = {1'b0, w_root[a][ond_pkg::ROOT_W-1:1]}
                     + {{(ond_pkg::OUT_W-1){1'b0}}, w_root[a][0]};
            if (w_neg[a]) begin
                n_fin[a] = -n_fin[a];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_fin <= n_fin;
        end
    end

    // Output and skid register control. The skid register fills only when a
    // result leaves the pipeline while the output register is full and
    // stalled; the output register reloads from it once the sink takes one.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_v  <= 1'b0;
            r_skid_v <= 1'b0;
        end else if (r_skid_v) begin
            if (o_normal.ready) begin
                r_skid_v <= 1'b0;
            end
        end else if (w_up_fire) begin
            if (r_out_v && !o_normal.ready) begin
                r_skid_v <= 1'b1;
            end else begin
                r_out_v <= 1'b1;
            end
        end else if (o_normal.ready) begin
            r_out_v <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_skid_v) begin
            if (o_normal.ready) begin
                r_out <= r_skid;
            end
        end else if (w_up_fire) begin
            if (r_out_v && !o_normal.ready) begin
                r_skid <= r_fin;
            end else begin
                r_out <= r_fin;
            end
        end
    end

    assign o_normal.valid    = r_out_v;
    assign o_normal.normal_x = r_out[ond_pkg::AX_X];
    assign o_normal.normal_y = r_out[ond_pkg::AX_Y];
    assign o_normal.normal_z = r_out[ond_pkg::AX_Z];

endmodule

`default_nettype wire
